// ===== src/round_robin_task_scheduler_macros.svh =====
// Assertion helpers used by the scheduler datapath.
`ifndef ROUND_ROBIN_TASK_SCHEDULER_MACROS_SVH
`define ROUND_ROBIN_TASK_SCHEDULER_MACROS_SVH

// Property checked on every clock edge outside reset.
`define RRTS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Condition in one cycle implies consequence in the next.
`define RRTS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== src/rrts_pkg.sv =====
package rrts_pkg;

  typedef enum logic [1:0] {
    KIND_TICK  = 2'd0,
    KIND_BLOCK = 2'd1,
    KIND_ABORT = 2'd2,
    KIND_LOAD  = 2'd3
  } kind_e;

  typedef enum logic {
    CFG_QUANTUM    = 1'b0,
    CFG_BLOCK_TIME = 1'b1
  } cfg_idx_e;

  localparam int unsigned ID_W      = 9;
  localparam int unsigned NEED_W    = 8;
  localparam int unsigned CFG_W     = 8;
  localparam int unsigned OT_W      = 16;
  localparam int unsigned S_TDATA_W = 24;
  localparam int unsigned M_TDATA_W = 112;

  localparam logic [CFG_W-1:0] QUANTUM_RST    = 8'd3;
  localparam logic [CFG_W-1:0] BLOCK_TIME_RST = 8'd8;

  typedef struct packed {
    logic capture;
    logic exec;
    logic admit;
    logic scan_init;
    logic scan_step;
    logic dispatch;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic is_load;
    logic admit_ok;
    logic scan_left;
    logic out_free;
  } sts_t;

endpackage

// ===== src/rrts_datapath.sv =====
module rrts_datapath #(
  parameter int unsigned MEM_SLOTS     = 4,
  parameter int unsigned PENDING_DEPTH = 16,
  parameter int unsigned TIME_BITS     = 16
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  rrts_pkg::cmd_t                   cmd_i,
  output rrts_pkg::sts_t                   sts_o,
  input  logic [1:0]                       s_tuser_i,
  input  logic [rrts_pkg::S_TDATA_W-1:0]   s_tdata_i,
  input  logic                             m_tready_i,
  output logic                             m_tvalid_o,
  output logic [rrts_pkg::M_TDATA_W-1:0]   m_tdata_o,
  input  logic                             cfg_we_i,
  input  logic                             cfg_idx_i,
  input  logic [rrts_pkg::CFG_W-1:0]       cfg_data_i
);
  import rrts_pkg::*;

  localparam int unsigned SLOT_W = (MEM_SLOTS > 1) ? $clog2(MEM_SLOTS) : 1;
  localparam int unsigned SCNT_W = $clog2(MEM_SLOTS + 1);
  localparam int unsigned PTR_W  = $clog2(PENDING_DEPTH);
  localparam int unsigned PCNT_W = $clog2(PENDING_DEPTH + 1);
  localparam int unsigned PE_W   = ID_W + NEED_W;

  // configuration
  logic [CFG_W-1:0] quantum_q, block_time_q;

  // captured item
  kind_e             kind_q;
  logic [ID_W-1:0]   new_id_q;
  logic [NEED_W-1:0] new_need_q;

  logic [TIME_BITS-1:0] clock_q, clock_d;

  // pending FIFO
  logic [PE_W-1:0]   pend_mem [PENDING_DEPTH];
  logic [PE_W-1:0]   pend_rd_q;
  logic [PTR_W-1:0]  pend_head_q, pend_head_d;
  logic [PCNT_W-1:0] pend_cnt_q, pend_cnt_d;
  logic [PTR_W:0]    tail_sum;
  logic [PTR_W-1:0]  pend_tail;
  logic              pend_full, pend_wr;

  // slot table
  logic                 busy_q    [MEM_SLOTS];
  logic                 busy_d    [MEM_SLOTS];
  logic                 started_q [MEM_SLOTS];
  logic                 started_d [MEM_SLOTS];
  logic [ID_W-1:0]      id_q      [MEM_SLOTS];
  logic [ID_W-1:0]      id_d      [MEM_SLOTS];
  logic [NEED_W-1:0]    need_q    [MEM_SLOTS];
  logic [NEED_W-1:0]    need_d    [MEM_SLOTS];
  logic [NEED_W-1:0]    elap_q    [MEM_SLOTS];
  logic [NEED_W-1:0]    elap_d    [MEM_SLOTS];
  logic [TIME_BITS-1:0] arr_q     [MEM_SLOTS];
  logic [TIME_BITS-1:0] arr_d     [MEM_SLOTS];
  logic [TIME_BITS-1:0] first_q   [MEM_SLOTS];
  logic [TIME_BITS-1:0] first_d   [MEM_SLOTS];
  logic [TIME_BITS-1:0] blkat_q   [MEM_SLOTS];
  logic [TIME_BITS-1:0] blkat_d   [MEM_SLOTS];

  // ready and blocked queues, head at entry zero
  logic [SLOT_W-1:0] rdy_q [MEM_SLOTS];
  logic [SLOT_W-1:0] rdy_d [MEM_SLOTS];
  logic [SLOT_W-1:0] blk_q [MEM_SLOTS];
  logic [SLOT_W-1:0] blk_d [MEM_SLOTS];
  logic [SCNT_W-1:0] rdy_cnt_q, rdy_cnt_d, blk_cnt_q, blk_cnt_d, scan_q, scan_d;
  logic [SCNT_W-1:0] rdy_base, blk_base;
  logic              r_push, r_pop, b_push, b_pop;
  logic [SLOT_W-1:0] r_val, b_val;

  logic              run_valid_q, run_valid_d;
  logic [SLOT_W-1:0] run_slot_q, run_slot_d;
  logic [CFG_W-1:0]  qused_q, qused_d;

  // result fields
  logic              done_valid_q, done_valid_d, done_err_q, done_err_d, rej_q, rej_d;
  logic [ID_W-1:0]   done_id_q, done_id_d;
  logic [OT_W-1:0]   done_arr_q, done_arr_d, done_wait_q, done_wait_d;
  logic [OT_W-1:0]   done_resp_q, done_resp_d, done_turn_q, done_turn_d;
  logic [NEED_W-1:0] done_svc_q, done_svc_d;

  logic                  m_valid_q, m_valid_d;
  logic [M_TDATA_W-1:0]  m_data_q, m_data_d;

  // single read port into the slot table
  logic [SLOT_W-1:0]    rd_slot, free_idx, s_sel;
  logic [ID_W-1:0]      cur_id;
  logic [NEED_W-1:0]    cur_need, cur_el, el, svc;
  logic [TIME_BITS-1:0] cur_arr, cur_first, cur_blkat, clk_nx, turn, bdiff;
  logic                 rv, retire_v, err, any_free;
  logic [CFG_W-1:0]     qu;

  assign rd_slot   = cmd_i.scan_step ? blk_q[0] : run_slot_q;
  assign cur_id    = id_q[rd_slot];
  assign cur_need  = need_q[rd_slot];
  assign cur_el    = elap_q[rd_slot];
  assign cur_arr   = arr_q[rd_slot];
  assign cur_first = first_q[rd_slot];
  assign cur_blkat = blkat_q[rd_slot];

  assign clk_nx    = clock_q + 1'b1;
  assign pend_full = (pend_cnt_q == PCNT_W'(PENDING_DEPTH));
  assign tail_sum  = (PTR_W+1)'(pend_head_q) + (PTR_W+1)'(pend_cnt_q);
  assign pend_tail = (tail_sum >= (PTR_W+1)'(PENDING_DEPTH))
                   ? PTR_W'(tail_sum - (PTR_W+1)'(PENDING_DEPTH)) : PTR_W'(tail_sum);
  assign pend_wr   = cmd_i.exec && (kind_q == KIND_LOAD) && !pend_full;
  assign bdiff     = clock_q - cur_blkat;

  always_comb begin
    any_free = 1'b0;
    free_idx = '0;
    for (int i = MEM_SLOTS - 1; i >= 0; i--) begin
      if (!busy_q[i]) begin
        any_free = 1'b1;
        free_idx = SLOT_W'(i);
      end
    end
  end

  always_comb begin
    clock_d     = clock_q;
    pend_head_d = pend_head_q;
    pend_cnt_d  = pend_cnt_q;
    busy_d      = busy_q;
    started_d   = started_q;
    id_d        = id_q;
    need_d      = need_q;
    elap_d      = elap_q;
    arr_d       = arr_q;
    first_d     = first_q;
    blkat_d     = blkat_q;
    scan_d      = scan_q;
    run_valid_d = run_valid_q;
    run_slot_d  = run_slot_q;
    qused_d     = qused_q;
    done_valid_d = done_valid_q;
    done_err_d   = done_err_q;
    done_id_d    = done_id_q;
    done_arr_d   = done_arr_q;
    done_wait_d  = done_wait_q;
    done_resp_d  = done_resp_q;
    done_turn_d  = done_turn_q;
    done_svc_d   = done_svc_q;
    rej_d        = rej_q;
    r_push = 1'b0; r_pop = 1'b0; r_val = '0;
    b_push = 1'b0; b_pop = 1'b0; b_val = '0;
    rv = run_valid_q; qu = qused_q; el = cur_el;
    retire_v = 1'b0; err = 1'b0; svc = '0; turn = '0; s_sel = '0;

    if (cmd_i.exec) begin
      done_valid_d = 1'b0; done_err_d = 1'b0; done_id_d = '0; done_arr_d = '0;
      done_wait_d = '0; done_resp_d = '0; done_turn_d = '0; done_svc_d = '0;
      rej_d = 1'b0;
      if (kind_q == KIND_LOAD) begin
        if (pend_full) rej_d = 1'b1;
        else pend_cnt_d = pend_cnt_q + 1'b1;
      end else begin
        clock_d = clk_nx;
        if (rv) begin
          el = (cur_el == '1) ? cur_el : cur_el + 1'b1;
          qu = (qused_q == '1) ? qused_q : qused_q + 1'b1;
          elap_d[run_slot_q] = el;
        end
        if (rv && kind_q == KIND_BLOCK) begin
          blkat_d[run_slot_q] = clk_nx;
          b_push = 1'b1;
          b_val  = run_slot_q;
          rv = 1'b0; qu = '0;
        end else if (rv && kind_q == KIND_ABORT) begin
          retire_v = 1'b1; err = 1'b1;
          rv = 1'b0; qu = '0;
        end
        if (rv && el >= cur_need) begin
          retire_v = 1'b1;
          rv = 1'b0; qu = '0;
        end else if (rv && qu >= quantum_q) begin
          r_push = 1'b1;
          r_val  = run_slot_q;
          rv = 1'b0; qu = '0;
        end
        if (retire_v) begin
          // completed tasks report their need, aborted ones what they ran
          svc  = err ? el : cur_need;
          turn = clk_nx - cur_arr;
          done_valid_d = 1'b1;
          done_err_d   = err;
          done_id_d    = cur_id;
          done_arr_d   = OT_W'(cur_arr);
          done_wait_d  = OT_W'(turn - TIME_BITS'(svc));
          done_resp_d  = OT_W'(cur_first - cur_arr);
          done_turn_d  = OT_W'(turn);
          done_svc_d   = svc;
          busy_d[run_slot_q]    = 1'b0;
          started_d[run_slot_q] = 1'b0;
        end
        run_valid_d = rv;
        qused_d     = qu;
      end
    end

    if (cmd_i.admit) begin
      busy_d[free_idx]    = 1'b1;
      started_d[free_idx] = 1'b0;
      id_d[free_idx]      = pend_rd_q[ID_W-1:0];
      need_d[free_idx]    = pend_rd_q[PE_W-1:ID_W];
      elap_d[free_idx]    = '0;
      arr_d[free_idx]     = clock_q;
      r_push = 1'b1;
      r_val  = free_idx;
      pend_head_d = (pend_head_q == PTR_W'(PENDING_DEPTH - 1)) ? '0 : pend_head_q + 1'b1;
      pend_cnt_d  = pend_cnt_q - 1'b1;
    end

    if (cmd_i.scan_init) scan_d = blk_cnt_q;

    // rotate the blocked list once: expired entries move to ready
    if (cmd_i.scan_step) begin
      b_pop = 1'b1;
      if (bdiff >= TIME_BITS'(block_time_q)) begin
        r_push = 1'b1;
        r_val  = blk_q[0];
      end else begin
        b_push = 1'b1;
        b_val  = blk_q[0];
      end
      scan_d = scan_q - 1'b1;
    end

    if (cmd_i.dispatch && !run_valid_q && rdy_cnt_q != '0) begin
      s_sel = rdy_q[0];
      r_pop = 1'b1;
      run_slot_d  = s_sel;
      run_valid_d = 1'b1;
      qused_d     = '0;
      if (!started_q[s_sel]) begin
        first_d[s_sel]   = clock_q;
        started_d[s_sel] = 1'b1;
      end
    end
  end

  // queue updates: at most one pop and one push per cycle
  always_comb begin
    rdy_d    = rdy_q;
    blk_d    = blk_q;
    rdy_base = rdy_cnt_q - SCNT_W'(r_pop);
    blk_base = blk_cnt_q - SCNT_W'(b_pop);
    if (r_pop) begin
      for (int i = 0; i < MEM_SLOTS - 1; i++) rdy_d[i] = rdy_q[i+1];
    end
    if (b_pop) begin
      for (int i = 0; i < MEM_SLOTS - 1; i++) blk_d[i] = blk_q[i+1];
    end
    for (int i = 0; i < MEM_SLOTS; i++) begin
      if (r_push && rdy_base == SCNT_W'(i)) rdy_d[i] = r_val;
      if (b_push && blk_base == SCNT_W'(i)) blk_d[i] = b_val;
    end
    rdy_cnt_d = rdy_base
              + SCNT_W'(r_push && rdy_base < SCNT_W'(MEM_SLOTS));
    blk_cnt_d = blk_base
              + SCNT_W'(b_push && blk_base < SCNT_W'(MEM_SLOTS));
  end

  always_comb begin
    m_valid_d = m_valid_q;
    m_data_d  = m_data_q;
    if (cmd_i.out_load) begin
      m_valid_d = 1'b1;
      m_data_d  = {2'b00, rej_q, done_svc_q, done_turn_q, done_resp_q, done_wait_q,
                   done_arr_q, done_err_q, done_id_q, done_valid_q,
                   run_valid_q ? cur_id : ID_W'(0), run_valid_q, OT_W'(clock_q)};
    end else if (m_tready_i) begin
      m_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      quantum_q    <= QUANTUM_RST;
      block_time_q <= BLOCK_TIME_RST;
      clock_q      <= '1;
      pend_head_q  <= '0;
      pend_cnt_q   <= '0;
      busy_q       <= '{default: 1'b0};
      started_q    <= '{default: 1'b0};
      rdy_cnt_q    <= '0;
      blk_cnt_q    <= '0;
      scan_q       <= '0;
      run_valid_q  <= 1'b0;
      run_slot_q   <= '0;
      qused_q      <= '0;
      m_valid_q    <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_idx_e'(cfg_idx_i))
          CFG_QUANTUM:    quantum_q    <= cfg_data_i;
          CFG_BLOCK_TIME: block_time_q <= cfg_data_i;
        endcase
      end
      clock_q     <= clock_d;
      pend_head_q <= pend_head_d;
      pend_cnt_q  <= pend_cnt_d;
      busy_q      <= busy_d;
      started_q   <= started_d;
      rdy_cnt_q   <= rdy_cnt_d;
      blk_cnt_q   <= blk_cnt_d;
      scan_q      <= scan_d;
      run_valid_q <= run_valid_d;
      run_slot_q  <= run_slot_d;
      qused_q     <= qused_d;
      m_valid_q   <= m_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      kind_q     <= kind_e'(s_tuser_i);
      new_id_q   <= s_tdata_i[ID_W-1:0];
      new_need_q <= s_tdata_i[PE_W-1:ID_W];
    end
    if (pend_wr) pend_mem[pend_tail] <= {new_need_q, new_id_q};
    pend_rd_q <= pend_mem[pend_head_q];
    id_q    <= id_d;
    need_q  <= need_d;
    elap_q  <= elap_d;
    arr_q   <= arr_d;
    first_q <= first_d;
    blkat_q <= blkat_d;
    rdy_q   <= rdy_d;
    blk_q   <= blk_d;
    done_valid_q <= done_valid_d;
    done_err_q   <= done_err_d;
    done_id_q    <= done_id_d;
    done_arr_q   <= done_arr_d;
    done_wait_q  <= done_wait_d;
    done_resp_q  <= done_resp_d;
    done_turn_q  <= done_turn_d;
    done_svc_q   <= done_svc_d;
    rej_q        <= rej_d;
    m_data_q     <= m_data_d;
  end

  assign sts_o.is_load   = (kind_q == KIND_LOAD);
  assign sts_o.admit_ok  = (pend_cnt_q != '0) && any_free;
  assign sts_o.scan_left = (scan_q != '0);
  assign sts_o.out_free  = !m_valid_q || m_tready_i;

  assign m_tvalid_o = m_valid_q;
  assign m_tdata_o  = m_data_q;

  `include "round_robin_task_scheduler_macros.svh"

  `RRTS_ASSERT(a_run_slot_busy, !run_valid_q || busy_q[run_slot_q],
               "running slot not resident")
  `RRTS_ASSERT(a_queue_bound,
               (32'(rdy_cnt_q) + 32'(blk_cnt_q) + 32'(run_valid_q)) <= MEM_SLOTS,
               "more queued tasks than slots")
  `RRTS_ASSERT(a_pend_bound, 32'(pend_cnt_q) <= PENDING_DEPTH, "pending count beyond depth")
  `RRTS_ASSERT_NEXT(a_dispatch, cmd_i.dispatch && !run_valid_q && rdy_cnt_q != '0,
                    run_valid_q, "dispatch did not start a task")

endmodule

// ===== src/rrts_ctrl.sv =====
module rrts_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           s_tvalid_i,
  output logic           s_tready_o,
  input  rrts_pkg::sts_t sts_i,
  output rrts_pkg::cmd_t cmd_o
);
  import rrts_pkg::*;

  typedef enum logic [6:0] {
    ST_IDLE   = 7'b0000001,
    ST_EXEC   = 7'b0000010,
    ST_ADM_RD = 7'b0000100,
    ST_ADM_WR = 7'b0001000,
    ST_SCAN   = 7'b0010000,
    ST_DISP   = 7'b0100000,
    ST_FIN    = 7'b1000000
  } state_e;

  state_e state_q, state_d;

  assign s_tready_o = (state_q == ST_IDLE);

  always_comb begin
    cmd_o   = '0;
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (s_tvalid_i) begin
          cmd_o.capture = 1'b1;
          state_d = ST_EXEC;
        end
      end
      ST_EXEC: begin
        cmd_o.exec = 1'b1;
        state_d = sts_i.is_load ? ST_FIN : ST_ADM_RD;
      end
      // pending head is read here, written to its slot in the next state
      ST_ADM_RD: begin
        if (sts_i.admit_ok) begin
          state_d = ST_ADM_WR;
        end else begin
          cmd_o.scan_init = 1'b1;
          state_d = ST_SCAN;
        end
      end
      ST_ADM_WR: begin
        cmd_o.admit = 1'b1;
        state_d = ST_ADM_RD;
      end
      ST_SCAN: begin
        if (sts_i.scan_left) cmd_o.scan_step = 1'b1;
        else state_d = ST_DISP;
      end
      ST_DISP: begin
        cmd_o.dispatch = 1'b1;
        state_d = ST_FIN;
      end
      ST_FIN: begin
        if (sts_i.out_free) begin
          cmd_o.out_load = 1'b1;
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

// ===== src/round_robin_task_scheduler.sv =====
// Channel   Dir  Signals                        Contents
// s         in   s_tvalid_i/s_tready_o          tuser: kind; tdata: new_id, new_max_time
// m         out  m_tvalid_o/m_tready_i          tdata: one status/retire record per item
// cfg       in   cfg_we_i/cfg_idx_i/cfg_data_i  0 quantum, 1 block_time
//
// A load runs capture, exec and output states; a tick adds a read and a write state
// per task admitted from pending (RAM read registered) and a step per blocked entry.
// One item is in flight at a time; the output register frees the next accept.
// No clearing pass after reset: all state needed is reset directly.
// A stalled m channel holds the record and delays the end of the next item only.
module round_robin_task_scheduler #(
  parameter int unsigned MEM_SLOTS     = 4,
  parameter int unsigned PENDING_DEPTH = 16,
  parameter int unsigned TIME_BITS     = 16
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           s_tvalid_i,
  output logic                           s_tready_o,
  input  logic [1:0]                     s_tuser_i,  // [1:0] kind
  input  logic [rrts_pkg::S_TDATA_W-1:0] s_tdata_i,  // [8:0] new_id, [16:9] new_max_time
  output logic                           m_tvalid_o,
  input  logic                           m_tready_i,
  // [15:0] time_now, [16] running_valid, [25:17] running_id, [26] done_valid,
  // [35:27] done_id, [36] done_error, [52:37] done_arrival, [68:53] done_waiting,
  // [84:69] done_response, [100:85] done_turnaround, [108:101] done_service,
  // [109] load_rejected
  output logic [rrts_pkg::M_TDATA_W-1:0] m_tdata_o,
  input  logic                           cfg_we_i,
  input  logic                           cfg_idx_i,
  input  logic [rrts_pkg::CFG_W-1:0]     cfg_data_i
);
  import rrts_pkg::*;

  cmd_t cmd;
  sts_t sts;

  rrts_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .s_tvalid_i (s_tvalid_i),
    .s_tready_o (s_tready_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  rrts_datapath #(
    .MEM_SLOTS     (MEM_SLOTS),
    .PENDING_DEPTH (PENDING_DEPTH),
    .TIME_BITS     (TIME_BITS)
  ) u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd),
    .sts_o      (sts),
    .s_tuser_i  (s_tuser_i),
    .s_tdata_i  (s_tdata_i),
    .m_tready_i (m_tready_i),
    .m_tvalid_o (m_tvalid_o),
    .m_tdata_o  (m_tdata_o),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i)
  );

endmodule
